// ===== src/aled_pkg.sv =====
// Shared types, timing constants and the gamma table of the LED bit encoder.
package aled_pkg;

  localparam int unsigned SLOTS = 24;

  localparam logic [6:0] LONG_TICKS_A  = 7'd80;
  localparam logic [6:0] SHORT_TICKS_A = 7'd40;
  localparam logic [6:0] LONG_TICKS_B  = 7'd96;
  localparam logic [6:0] SHORT_TICKS_B = 7'd24;

  localparam logic [1:0] GAMMA_TABLE = 2'd0;
  localparam logic [1:0] GAMMA_QUAD  = 2'd1;

  localparam logic OP_COLOUR = 1'b0;
  localparam logic OP_ZERO   = 1'b1;

  localparam logic [4:0] LAST_SLOT = 5'd23;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       disabled;
    logic       last_led;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pulse_width;
    logic       last_bit;
    logic       last_of_frame;
  } out_item_t;

  // One classified LED slot: corrected bytes in line order (green, red, blue).
  typedef struct packed {
    logic [23:0] bits;
    logic        zero;
    logic        frame_end;
  } slot_t;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4,
    8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
    8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
    8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd14, 8'd14,
    8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19,
    8'd20, 8'd20, 8'd21, 8'd21,
    8'd22, 8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd26, 8'd26, 8'd27, 8'd28,
    8'd28, 8'd29, 8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35,
    8'd35, 8'd36, 8'd37, 8'd38,
    8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46,
    8'd47, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
    8'd56, 8'd56, 8'd57, 8'd58,
    8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68,
    8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
    8'd80, 8'd81, 8'd82, 8'd84,
    8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95,
    8'd97, 8'd98, 8'd99, 8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107,
    8'd108, 8'd109, 8'd111,
    8'd112, 8'd113, 8'd115, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123,
    8'd124, 8'd126, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136,
    8'd137,
    8'd139, 8'd140, 8'd142, 8'd143, 8'd145, 8'd146, 8'd148, 8'd149, 8'd151,
    8'd152, 8'd154, 8'd155, 8'd157, 8'd158, 8'd160, 8'd162, 8'd163, 8'd165,
    8'd166,
    8'd168, 8'd170, 8'd171, 8'd173, 8'd175, 8'd176, 8'd178, 8'd180, 8'd181,
    8'd183, 8'd185, 8'd186, 8'd188, 8'd190, 8'd192, 8'd193, 8'd195, 8'd197,
    8'd199,
    8'd200, 8'd202, 8'd204, 8'd206, 8'd207, 8'd209, 8'd211, 8'd213, 8'd215,
    8'd217, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd233,
    8'd235, 8'd237, 8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251,
    8'd253, 8'd255
  };

endpackage

// ===== src/aled_front.sv =====
// Front end: accepts LED items, applies blanking and gamma, registers the slot.
module aled_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aled_pkg::in_item_t in_data,
  input  logic [1:0]        gamma_mode,
  output logic              slot_vld,
  output aled_pkg::slot_t   slot_data,
  input  logic              slot_full
);

  logic            vld_r, vld_nxt;
  aled_pkg::slot_t slot_r, slot_nxt;
  logic            accept;
  logic [7:0]      r_raw, g_raw, b_raw;
  logic [7:0]      r_cor, g_cor, b_cor;

  function automatic logic [7:0] correct(input logic [7:0] v, input logic [1:0] mode);
    logic [15:0] prod;
    logic [7:0]  res;
    prod = ({8'd0, v} * {8'd0, v}) + {8'd0, v};
    unique case (mode)
      aled_pkg::GAMMA_TABLE: res = aled_pkg::GAMMA_LUT[v];
      aled_pkg::GAMMA_QUAD:  res = prod[15:8];
      default:               res = v;
    endcase
    return res;
  endfunction

  assign in_stall = vld_r & slot_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    r_raw = in_data.disabled ? 8'd0 : in_data.red;
    g_raw = in_data.disabled ? 8'd0 : in_data.green;
    b_raw = in_data.disabled ? 8'd0 : in_data.blue;
    r_cor = correct(r_raw, gamma_mode);
    g_cor = correct(g_raw, gamma_mode);
    b_cor = correct(b_raw, gamma_mode);
    slot_nxt.zero      = (in_data.op == aled_pkg::OP_ZERO);
    slot_nxt.frame_end = in_data.last_led;
    slot_nxt.bits      = slot_nxt.zero ? 24'd0 : {g_cor, r_cor, b_cor};
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (!slot_full) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_vld  = vld_r;
  assign slot_data = slot_r;

endmodule

// ===== src/aled_fifo.sv =====
// Short queue of classified LED slots between the front and back ends.
module aled_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aled_pkg::slot_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            rd_vld,
  output aled_pkg::slot_t rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  aled_pkg::slot_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign rd_vld  = (cnt_r != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & rd_vld;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/aled_back.sv =====
// Back end: serialises one queued slot into 24 registered pulse widths.
module aled_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               timing_sel,
  input  logic               q_vld,
  input  aled_pkg::slot_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output aled_pkg::out_item_t out_data
);

  logic                cur_vld_r, cur_vld_nxt;
  aled_pkg::slot_t     cur_r;
  logic [4:0]          idx_r, idx_nxt;
  logic                out_vld_r, out_vld_nxt;
  aled_pkg::out_item_t out_r, out_nxt;
  logic                adv, at_last, cur_bit;
  logic [4:0]          bit_pos;
  logic [6:0]          long_w, short_w;

  assign long_w  = timing_sel ? aled_pkg::LONG_TICKS_B  : aled_pkg::LONG_TICKS_A;
  assign short_w = timing_sel ? aled_pkg::SHORT_TICKS_B : aled_pkg::SHORT_TICKS_A;

  assign at_last = (idx_r == aled_pkg::LAST_SLOT);
  assign adv     = cur_vld_r & (~out_vld_r | ~out_stall);
  assign q_pop   = q_vld & (~cur_vld_r | (adv & at_last));
  assign bit_pos = aled_pkg::LAST_SLOT - idx_r;
  assign cur_bit = cur_r.bits[bit_pos];

  always_comb begin
    out_nxt.pulse_width   = cur_r.zero ? 7'd0 : (cur_bit ? long_w : short_w);
    out_nxt.last_bit      = at_last;
    out_nxt.last_of_frame = at_last & cur_r.frame_end;

    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end

    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      idx_nxt     = 5'd0;
    end else if (adv) begin
      if (at_last) begin
        cur_vld_nxt = 1'b0;
        idx_nxt     = 5'd0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 5'd0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== src/addressable_led_bit_encoder.sv =====
// Top level of the addressable LED bit encoder: register port, front, queue and back.
// Path: a slot passes the front-end register, the queue, the back-end slot register and the output register.
// Throughput: set by the back end, which emits one bit slot per cycle while the output is not stalled.
// The front end keeps accepting while the queue has room, so idle gaps upstream are absorbed.
// Reset (rst_n low, synchronous) empties the pipeline and queue and clears both registers.
module addressable_led_bit_encoder #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aled_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aled_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  // Register 0 (timing_sel) sits at byte address 0 and register 1 (gamma_mode) at 4.
  // Only address bit 2 is decoded, so the low byte-offset bits are ignored.
  logic       timing_sel_r, timing_sel_nxt;
  logic [1:0] gamma_mode_r, gamma_mode_nxt;
  logic       cfg_wr;

  // Classified slot between the front end and the queue.
  logic            fr_vld;
  aled_pkg::slot_t fr_data;
  logic            q_full;

  // Queue head towards the back end.
  logic            q_vld;
  aled_pkg::slot_t q_data;
  logic            q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    timing_sel_nxt = timing_sel_r;
    gamma_mode_nxt = gamma_mode_r;
    if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        gamma_mode_nxt = cfg_pwdata[1:0];
      end else begin
        timing_sel_nxt = cfg_pwdata[0];
      end
    end
    cfg_prdata = cfg_paddr[2] ? {30'd0, gamma_mode_r} : {31'd0, timing_sel_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_sel_r <= 1'b0;
      gamma_mode_r <= 2'd0;
    end else begin
      timing_sel_r <= timing_sel_nxt;
      gamma_mode_r <= gamma_mode_nxt;
    end
  end

  // The front end blanks disabled LEDs, applies gamma and packs the bytes in
  // line order; a zero slot is reduced to an all-zero flag here.
  aled_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .gamma_mode (gamma_mode_r),
    .slot_vld   (fr_vld),
    .slot_data  (fr_data),
    .slot_full  (q_full)
  );

  // The queue lets the front end run ahead while the back end is busy serialising.
  aled_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_vld),
    .wr_data (fr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_vld  (q_vld),
    .rd_data (q_data)
  );

  // The back end walks the 24 bits MSB first and drives a registered output,
  // loading the next slot in the same cycle as the last bit of the current one.
  aled_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing_sel (timing_sel_r),
    .q_vld      (q_vld),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== test/addressable_led_bit_encoder_tb.sv =====
// Self-checking testbench for the addressable LED bit encoder: pulse widths predicted per LED slot.
module addressable_led_bit_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Gamma modes that the package leaves unnamed. The spare code must behave as no correction.
  localparam logic [1:0] GAMMA_NONE  = 2'd2;
  localparam logic [1:0] GAMMA_SPARE = 2'd3;

  // LED type codes, named after the long and short high times that they select.
  localparam logic TYPE_80_40 = 1'b0;
  localparam logic TYPE_96_24 = 1'b1;

  // Byte addresses of the two registers on the configuration port.
  localparam logic [2:0] ADDR_TIMING_SEL = 3'd0;
  localparam logic [2:0] ADDR_GAMMA_MODE = 3'd4;

  localparam int STALL_PERCENT   = 19;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 28;

  // Expands every accepted LED slot into its 24 expected bit slots and checks the results
  // against them in order.
  class led_slot_predictor;
    logic                timing_sel;
    logic [1:0]          gamma_mode;
    aled_pkg::out_item_t expected_slots[$];
    int                  mismatches;

    function new();
      timing_sel = TYPE_80_40;
      gamma_mode = aled_pkg::GAMMA_TABLE;
      mismatches = 0;
    endfunction

    function logic [7:0] corrected_level(logic [7:0] level);
      logic [16:0] square;
      square = 17'(level) * 17'(level) + 17'(level);
      case (gamma_mode)
        aled_pkg::GAMMA_TABLE: return aled_pkg::GAMMA_LUT[level];
        aled_pkg::GAMMA_QUAD:  return square[15:8];
        default:               return level;
      endcase
    endfunction

    function void note_item(aled_pkg::in_item_t item);
      logic [7:0]          red_level;
      logic [7:0]          green_level;
      logic [7:0]          blue_level;
      logic [23:0]         line_bits;
      logic [6:0]          long_ticks;
      logic [6:0]          short_ticks;
      aled_pkg::out_item_t slot;
      red_level   = item.disabled ? 8'd0 : item.red;
      green_level = item.disabled ? 8'd0 : item.green;
      blue_level  = item.disabled ? 8'd0 : item.blue;
      line_bits   = {corrected_level(green_level), corrected_level(red_level),
                     corrected_level(blue_level)};
      long_ticks  = (timing_sel == TYPE_96_24) ? aled_pkg::LONG_TICKS_B
                                               : aled_pkg::LONG_TICKS_A;
      short_ticks = (timing_sel == TYPE_96_24) ? aled_pkg::SHORT_TICKS_B
                                               : aled_pkg::SHORT_TICKS_A;
      for (int k = 0; k < aled_pkg::SLOTS; k++) begin
        if (item.op == aled_pkg::OP_ZERO) begin
          slot.pulse_width = 7'd0;
        end else begin
          slot.pulse_width = line_bits[aled_pkg::SLOTS - 1 - k] ? long_ticks : short_ticks;
        end
        slot.last_bit      = (k == aled_pkg::SLOTS - 1);
        slot.last_of_frame = (k == aled_pkg::SLOTS - 1) && item.last_led;
        expected_slots.push_back(slot);
      end
    endfunction

    function void check_slot(aled_pkg::out_item_t got);
      aled_pkg::out_item_t want;
      if (expected_slots.size() == 0) begin
        $error("bit slot %0h arrived with nothing expected", got);
        mismatches++;
        return;
      end
      want = expected_slots.pop_front();
      if (got.pulse_width !== want.pulse_width) begin
        $error("pulse_width: expected %0d, got %0d", want.pulse_width, got.pulse_width);
        mismatches++;
      end
      if (got.last_bit !== want.last_bit) begin
        $error("last_bit: expected %0d, got %0d", want.last_bit, got.last_bit);
        mismatches++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, got.last_of_frame);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  aled_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  aled_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [2:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  led_slot_predictor slots;

  // When steady is set neither side idles, so the block runs back to back at full rate.
  bit steady;
  // A request from the stimulus for the receiver to hold off for a long stretch.
  bit hold_off_req;
  int quiet_cycles;

  logic       phase_type  [PHASES];
  logic [1:0] phase_gamma [PHASES];

  addressable_led_bit_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // All inputs change with nonblocking assignments at the rising edge, so a process that
  // wakes on that edge still sees the values that the edge itself sampled. The monitors
  // below rely on this to see exactly which transactions were taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      slots.note_item(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      slots.check_slot(out_data);
    end
  end

  // The watchdog counts cycles in which neither channel moves a transaction. The long
  // hold-off of the receiver and the pauses around register writes stay well below it.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It stalls at random, except in the steady stretch. On request it holds off
  // once for a long stretch of its own, while the sender keeps offering, so that the queue
  // inside the block fills and the input side is stalled too.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < STALL_PERCENT);
      end
    end
  end

  function automatic aled_pkg::in_item_t make_item(logic op, logic [7:0] red,
                                                   logic [7:0] green, logic [7:0] blue,
                                                   logic disabled, logic last_led);
    aled_pkg::in_item_t item;
    item.op       = op;
    item.red      = red;
    item.green    = green;
    item.blue     = blue;
    item.disabled = disabled;
    item.last_led = last_led;
    return item;
  endfunction

  // Colour levels favour the two ends of the range now and then.
  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic aled_pkg::in_item_t random_led_item();
    return make_item(($urandom_range(0, 99) < 15) ? aled_pkg::OP_ZERO : aled_pkg::OP_COLOUR,
                     random_level(), random_level(), random_level(),
                     $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 20);
  endfunction

  // Offers one LED slot and returns at the edge that takes it. Idle cycles come first, so
  // the valid line is driven only once in any time step.
  task automatic send_item(aled_pkg::in_item_t item);
    while (!steady && ($urandom_range(0, 99) < STALL_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Every transaction causes results, so the block is idle once the last expected bit slot
  // is out; a short pause covers the pipeline depth before the register changes. The first
  // edge lets the monitor note a transaction taken at the edge on which this task starts.
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (slots.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      ADDR_TIMING_SEL: slots.timing_sel = value[0];
      ADDR_GAMMA_MODE: slots.gamma_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_encoding(logic timing_sel, logic [1:0] gamma_mode);
    write_register(ADDR_TIMING_SEL, 32'(timing_sel));
    write_register(ADDR_GAMMA_MODE, 32'(gamma_mode));
  endtask

  initial begin
    slots        = new();
    steady       = 1'b0;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;

    phase_type  = '{TYPE_80_40, TYPE_96_24, TYPE_96_24, TYPE_80_40,
                    TYPE_96_24, TYPE_80_40, TYPE_80_40, TYPE_96_24};
    phase_gamma = '{aled_pkg::GAMMA_TABLE, aled_pkg::GAMMA_QUAD, GAMMA_NONE, GAMMA_SPARE,
                    aled_pkg::GAMMA_TABLE, GAMMA_SPARE, aled_pkg::GAMMA_QUAD, GAMMA_NONE};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under the reset settings: table gamma with the 80/40 times.
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'h01, 8'h80, 8'hAA, 1'b0, 1'b1));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd12, 8'd11, 8'd128, 1'b0, 1'b0));
    // A disabled LED sends only short pulses, whatever its colour bytes say.
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    // A zero slot ignores colour and the disable flag but still marks its last bit.
    send_item(make_item(aled_pkg::OP_ZERO, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    send_item(make_item(aled_pkg::OP_ZERO, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));

    set_encoding(TYPE_96_24, aled_pkg::GAMMA_QUAD);
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd15, 8'd16, 8'd200, 1'b0, 1'b1));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd0, 8'd255, 8'd1, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1));
    send_item(make_item(aled_pkg::OP_ZERO, 8'd90, 8'd20, 8'd7, 1'b0, 1'b1));

    set_encoding(TYPE_80_40, GAMMA_NONE);
    send_item(make_item(aled_pkg::OP_COLOUR, 8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'h55, 8'hAA, 8'h0F, 1'b1, 1'b0));

    // The spare gamma code must pass the levels through unchanged.
    set_encoding(TYPE_96_24, GAMMA_SPARE);
    send_item(make_item(aled_pkg::OP_COLOUR, 8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(aled_pkg::OP_COLOUR, 8'h81, 8'h7E, 8'h00, 1'b0, 1'b1));
    send_item(make_item(aled_pkg::OP_ZERO, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));

    // Random part, one phase per setting. One phase runs with no idling on either side,
    // another starts with a long hold-off at the receiver.
    for (int p = 0; p < PHASES; p++) begin
      set_encoding(phase_type[p], phase_gamma[p]);
      steady = (p == 2);
      if (p == 5) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_led_item());
      end
    end
    steady   = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    while (slots.pending() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    if (slots.pending() != 0) begin
      $error("%0d expected bit slots never arrived", slots.pending());
    end
    if (slots.mismatches == 0 && slots.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/aled_pkg.sv
src/aled_front.sv
src/aled_fifo.sv
src/aled_back.sv
src/addressable_led_bit_encoder.sv
test/addressable_led_bit_encoder_tb.sv
